/* design/qrv_pkg.sv */
// Shared types and widths for the quaternion vector rotation pipeline.
// No dependencies; used by every qrv_* module and the top level.

package qrv_pkg;

    localparam int QW   = 16;            // quaternion component width
    localparam int VW   = 16;            // vector component width
    localparam int OW   = 18;            // result component width
    localparam int P1_W = QW + VW;       // q * v product
    localparam int T_W  = P1_W + 1;      // sum of three products
    localparam int P2_W = T_W + QW;      // t * q product
    localparam int R_W  = P2_W + 3;      // sum of four products

    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;

    typedef struct packed {
        logic first;
        logic second;
    } t_stage_en;

    typedef struct packed {
        logic signed [QW-1:0] k;
        logic signed [QW-1:0] j;
        logic signed [QW-1:0] i;
        logic signed [QW-1:0] s;
    } t_quat;

endpackage

/* design/quaternion_rotate_vector_core.sv */
// Quaternion vector rotation q * v * conj(q), fully pipelined.
// Throughput one beat per cycle while the output is not stalled by m_axis_tready.
// Five register stages (product, sum, product, sum, round/saturate) advance under
// per-stage enables, so a stalled output holds its beat and bubbles collapse.
// Reset (synchronous, active low) clears the stage valid bits only.
// Depends on qrv_pkg, qrv_vec_mult, qrv_conj_mult, qrv_round_sat.

module quaternion_rotate_vector_core #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // quat_scalar, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z (16 bits each)
    input  logic [111:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // rot_x, rot_y, rot_z (18 bits each), 2 zero pad bits
    output logic [55:0]   m_axis_tdata,
    // saturated
    output logic          m_axis_tuser
);

    localparam int VW = qrv_pkg::VW;
    localparam int OW = qrv_pkg::OW;

    logic [4:0] r_vld;
    logic [4:0] w_en;

    qrv_pkg::t_quat                  w_q_in;
    qrv_pkg::t_quat                  w_q_mid;
    logic signed [qrv_pkg::T_W-1:0]  w_tw, w_tx, w_ty, w_tz;
    logic signed [qrv_pkg::R_W-1:0]  w_r   [3];
    logic signed [OW-1:0]            w_rot [3];
    logic                            w_sat;
    qrv_pkg::t_stage_en              w_en_a;
    qrv_pkg::t_stage_en              w_en_b;

    assign w_en[4] = !r_vld[4] || m_axis_tready;
    assign w_en[3] = !r_vld[3] || w_en[4];
    assign w_en[2] = !r_vld[2] || w_en[3];
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= s_axis_tvalid;
            for (int s = 1; s < 5; s++) begin
                if (w_en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign s_axis_tready = w_en[0];

    assign w_q_in.s = s_axis_tdata[15:0];
    assign w_q_in.i = s_axis_tdata[31:16];
    assign w_q_in.j = s_axis_tdata[47:32];
    assign w_q_in.k = s_axis_tdata[63:48];

    assign w_en_a.first  = w_en[0];
    assign w_en_a.second = w_en[1];
    assign w_en_b.first  = w_en[2];
    assign w_en_b.second = w_en[3];

    qrv_vec_mult u_vec_mult (
        .i_clk (i_clk),
        .i_en  (w_en_a),
        .i_q   (w_q_in),
        .i_vx  (s_axis_tdata[64 +: VW]),
        .i_vy  (s_axis_tdata[80 +: VW]),
        .i_vz  (s_axis_tdata[96 +: VW]),
        .o_q   (w_q_mid),
        .o_tw  (w_tw),
        .o_tx  (w_tx),
        .o_ty  (w_ty),
        .o_tz  (w_tz)
    );

    qrv_conj_mult u_conj_mult (
        .i_clk (i_clk),
        .i_en  (w_en_b),
        .i_q   (w_q_mid),
        .i_tw  (w_tw),
        .i_tx  (w_tx),
        .i_ty  (w_ty),
        .i_tz  (w_tz),
        .o_rx  (w_r[0]),
        .o_ry  (w_r[1]),
        .o_rz  (w_r[2])
    );

    qrv_round_sat #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_round_sat (
        .i_clk (i_clk),
        .i_en  (w_en[4]),
        .i_r   (w_r),
        .o_rot (w_rot),
        .o_sat (w_sat)
    );

    assign m_axis_tvalid = r_vld[4];
    assign m_axis_tdata  = {2'b00, w_rot[2], w_rot[1], w_rot[0]};
    assign m_axis_tuser  = w_sat;

endmodule

/* design/qrv_vec_mult.sv */
// First Hamilton product t = q * (0, v), two register stages.
// Depends on qrv_pkg.

module qrv_vec_mult (
    input  logic                              i_clk,
    input  qrv_pkg::t_stage_en                i_en,
    input  qrv_pkg::t_quat                    i_q,
    input  logic signed [qrv_pkg::VW-1:0]     i_vx,
    input  logic signed [qrv_pkg::VW-1:0]     i_vy,
    input  logic signed [qrv_pkg::VW-1:0]     i_vz,
    output qrv_pkg::t_quat                    o_q,
    output logic signed [qrv_pkg::T_W-1:0]    o_tw,
    output logic signed [qrv_pkg::T_W-1:0]    o_tx,
    output logic signed [qrv_pkg::T_W-1:0]    o_ty,
    output logic signed [qrv_pkg::T_W-1:0]    o_tz
);

    localparam int PW = qrv_pkg::P1_W;
    localparam int TW = qrv_pkg::T_W;

    logic signed [PW-1:0] r_p [12];
    logic signed [PW-1:0] n_p [12];
    qrv_pkg::t_quat       r_q1;
    qrv_pkg::t_quat       r_q2;
    logic signed [TW-1:0] r_tw, r_tx, r_ty, r_tz;

    always_comb begin
        n_p[0]  = PW'(i_q.i) * PW'(i_vx);
        n_p[1]  = PW'(i_q.j) * PW'(i_vy);
        n_p[2]  = PW'(i_q.k) * PW'(i_vz);
        n_p[3]  = PW'(i_q.s) * PW'(i_vx);
        n_p[4]  = PW'(i_q.j) * PW'(i_vz);
        n_p[5]  = PW'(i_q.k) * PW'(i_vy);
        n_p[6]  = PW'(i_q.s) * PW'(i_vy);
        n_p[7]  = PW'(i_q.k) * PW'(i_vx);
        n_p[8]  = PW'(i_q.i) * PW'(i_vz);
        n_p[9]  = PW'(i_q.s) * PW'(i_vz);
        n_p[10] = PW'(i_q.i) * PW'(i_vy);
        n_p[11] = PW'(i_q.j) * PW'(i_vx);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.first) begin
            r_p  <= n_p;
            r_q1 <= i_q;
        end
        if (i_en.second) begin
            r_q2 <= r_q1;
            r_tw <= -(TW'(r_p[0]) + TW'(r_p[1]) + TW'(r_p[2]));
            r_tx <= TW'(r_p[3]) + TW'(r_p[4]) - TW'(r_p[5]);
            r_ty <= TW'(r_p[6]) + TW'(r_p[7]) - TW'(r_p[8]);
            r_tz <= TW'(r_p[9]) + TW'(r_p[10]) - TW'(r_p[11]);
        end
    end

    assign o_q  = r_q2;
    assign o_tw = r_tw;
    assign o_tx = r_tx;
    assign o_ty = r_ty;
    assign o_tz = r_tz;

endmodule

/* design/qrv_conj_mult.sv */
// Second Hamilton product r = t * conj(q), vector part, two register stages.
// Depends on qrv_pkg.

module qrv_conj_mult (
    input  logic                              i_clk,
    input  qrv_pkg::t_stage_en                i_en,
    input  qrv_pkg::t_quat                    i_q,
    input  logic signed [qrv_pkg::T_W-1:0]    i_tw,
    input  logic signed [qrv_pkg::T_W-1:0]    i_tx,
    input  logic signed [qrv_pkg::T_W-1:0]    i_ty,
    input  logic signed [qrv_pkg::T_W-1:0]    i_tz,
    output logic signed [qrv_pkg::R_W-1:0]    o_rx,
    output logic signed [qrv_pkg::R_W-1:0]    o_ry,
    output logic signed [qrv_pkg::R_W-1:0]    o_rz
);

    localparam int PW = qrv_pkg::P2_W;
    localparam int RW = qrv_pkg::R_W;

    logic signed [PW-1:0] r_p [12];
    logic signed [PW-1:0] n_p [12];
    logic signed [RW-1:0] r_rx, r_ry, r_rz;

    always_comb begin
        // x: -tw*qi + tx*qs - ty*qk + tz*qj
        n_p[0]  = PW'(i_tw) * PW'(i_q.i);
        n_p[1]  = PW'(i_tx) * PW'(i_q.s);
        n_p[2]  = PW'(i_ty) * PW'(i_q.k);
        n_p[3]  = PW'(i_tz) * PW'(i_q.j);
        // y: -tw*qj + ty*qs - tz*qi + tx*qk
        n_p[4]  = PW'(i_tw) * PW'(i_q.j);
        n_p[5]  = PW'(i_ty) * PW'(i_q.s);
        n_p[6]  = PW'(i_tz) * PW'(i_q.i);
        n_p[7]  = PW'(i_tx) * PW'(i_q.k);
        // z: -tw*qk + tz*qs - tx*qj + ty*qi
        n_p[8]  = PW'(i_tw) * PW'(i_q.k);
        n_p[9]  = PW'(i_tz) * PW'(i_q.s);
        n_p[10] = PW'(i_tx) * PW'(i_q.j);
        n_p[11] = PW'(i_ty) * PW'(i_q.i);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.first) begin
            r_p <= n_p;
        end
        if (i_en.second) begin
            r_rx <= RW'(r_p[1]) - RW'(r_p[0]) - RW'(r_p[2]) + RW'(r_p[3]);
            r_ry <= RW'(r_p[5]) - RW'(r_p[4]) - RW'(r_p[6]) + RW'(r_p[7]);
            r_rz <= RW'(r_p[9]) - RW'(r_p[8]) - RW'(r_p[10]) + RW'(r_p[11]);
        end
    end

    assign o_rx = r_rx;
    assign o_ry = r_ry;
    assign o_rz = r_rz;

endmodule

/* design/qrv_round_sat.sv */
// Round to nearest (ties up), drop the fraction bits and saturate; output register.
// Depends on qrv_pkg.

module qrv_round_sat #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [qrv_pkg::R_W-1:0]    i_r [3],
    output logic signed [qrv_pkg::OW-1:0]     o_rot [3],
    output logic                              o_sat
);

    localparam int SH    = 2 * QUAT_FRAC_BITS;
    localparam int BASE  = (SH + 1 > qrv_pkg::R_W) ? SH + 1 : qrv_pkg::R_W;
    localparam int ACC_W = BASE + 1;
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (SH - 1);
    localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'(qrv_pkg::OUT_MAX);
    localparam logic signed [ACC_W-1:0] MIN_V = ACC_W'(qrv_pkg::OUT_MIN);

    logic signed [ACC_W-1:0]      w_q   [3];
    logic signed [qrv_pkg::OW-1:0] n_rot [3];
    logic                         n_sat;
    logic signed [qrv_pkg::OW-1:0] r_rot [3];
    logic                         r_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            w_q[c] = (ACC_W'(i_r[c]) + HALF) >>> SH;
            if (w_q[c] > MAX_V) begin
                n_rot[c] = qrv_pkg::OW'(qrv_pkg::OUT_MAX);
                n_sat    = 1'b1;
            end else if (w_q[c] < MIN_V) begin
                n_rot[c] = qrv_pkg::OW'(qrv_pkg::OUT_MIN);
                n_sat    = 1'b1;
            end else begin
                n_rot[c] = w_q[c][qrv_pkg::OW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
            r_sat <= n_sat;
        end
    end

    assign o_rot = r_rot;
    assign o_sat = r_sat;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for quaternion_rotate_vector_core: random and directed beats,
// predicted with exact 64-bit integer math and checked in order by a scoreboard class.
// Depends on qrv_pkg and the quaternion_rotate_vector_core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC        = 14;
    localparam int HALF_PERIOD = 10;
    localparam int RAND_BEATS  = 1700;

    typedef struct {
        logic signed [qrv_pkg::OW-1:0] x;
        logic signed [qrv_pkg::OW-1:0] y;
        logic signed [qrv_pkg::OW-1:0] z;
        logic                          sat;
    } t_rot_result;

    // x in the lowest bits
    typedef struct packed {
        logic signed [qrv_pkg::VW-1:0] z;
        logic signed [qrv_pkg::VW-1:0] y;
        logic signed [qrv_pkg::VW-1:0] x;
    } t_vec3;

    class rotation_scoreboard;
        t_rot_result rot_expect_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // v' = q * v * conj(q), rounded half up and clipped to the output width
        function automatic t_rot_result rotate_vector(qrv_pkg::t_quat q, t_vec3 v);
            longint qw, qx, qy, qz, vx, vy, vz;
            longint tw, tx, ty, tz;
            longint r[3];
            longint rnd;
            t_rot_result res;
            logic signed [qrv_pkg::OW-1:0] comp[3];
            qw = q.s;
            qx = q.i;
            qy = q.j;
            qz = q.k;
            vx = v.x;
            vy = v.y;
            vz = v.z;
            tw = -qx * vx - qy * vy - qz * vz;
            tx = qw * vx + qy * vz - qz * vy;
            ty = qw * vy + qz * vx - qx * vz;
            tz = qw * vz + qx * vy - qy * vx;
            r[0] = -tw * qx + tx * qw - ty * qz + tz * qy;
            r[1] = -tw * qy + ty * qw - tz * qx + tx * qz;
            r[2] = -tw * qz + tz * qw - tx * qy + ty * qx;
            res.sat = 1'b0;
            for (int n = 0; n < 3; n++) begin
                rnd = (r[n] + (longint'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
                if (rnd > qrv_pkg::OUT_MAX) begin
                    rnd = qrv_pkg::OUT_MAX;
                    res.sat = 1'b1;
                end else if (rnd < qrv_pkg::OUT_MIN) begin
                    rnd = qrv_pkg::OUT_MIN;
                    res.sat = 1'b1;
                end
                comp[n] = rnd[qrv_pkg::OW-1:0];
            end
            res.x = comp[0];
            res.y = comp[1];
            res.z = comp[2];
            return res;
        endfunction

        function void note_input(logic [111:0] beat);
            qrv_pkg::t_quat q;
            t_vec3 v;
            q = beat[63:0];
            v = beat[111:64];
            rot_expect_q.push_back(rotate_vector(q, v));
        endfunction

        function void check_result(logic [55:0] beat, logic sat);
            t_rot_result exp_res;
            logic signed [qrv_pkg::OW-1:0] act_x, act_y, act_z;
            act_x = beat[17:0];
            act_y = beat[35:18];
            act_z = beat[53:36];
            if (rot_expect_q.size() == 0) begin
                $error("output beat with no pending input: rot_x %0d rot_y %0d rot_z %0d",
                       act_x, act_y, act_z);
                errors++;
                return;
            end
            exp_res = rot_expect_q.pop_front();
            if (act_x !== exp_res.x) begin
                $error("rot_x: expected %0d, actual %0d", exp_res.x, act_x);
                errors++;
            end
            if (act_y !== exp_res.y) begin
                $error("rot_y: expected %0d, actual %0d", exp_res.y, act_y);
                errors++;
            end
            if (act_z !== exp_res.z) begin
                $error("rot_z: expected %0d, actual %0d", exp_res.z, act_z);
                errors++;
            end
            if (sat !== exp_res.sat) begin
                $error("saturated: expected %0d, actual %0d", exp_res.sat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return rot_expect_q.size();
        endfunction
    endclass

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // quat_scalar, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z
    logic [111:0]  s_axis_tdata  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // rot_x, rot_y, rot_z, 2 pad bits
    logic [55:0]   m_axis_tdata;
    // saturated
    logic          m_axis_tuser;

    int send_idle_pct = 20;
    int recv_idle_pct = 51;

    rotation_scoreboard sb = new();

    always #(HALF_PERIOD) i_clk = ~i_clk;

    quaternion_rotate_vector_core #(
        .QUAT_FRAC_BITS(FRAC)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [111:0] pack_beat(int s, int qi, int qj, int qk,
                                               int vx, int vy, int vz);
        logic [15:0] f[7];
        f[0] = 16'(s);
        f[1] = 16'(qi);
        f[2] = 16'(qj);
        f[3] = 16'(qk);
        f[4] = 16'(vx);
        f[5] = 16'(vy);
        f[6] = 16'(vz);
        return {f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    function automatic logic [15:0] edge_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7FFF;
            6: return 16'h4000;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic logic [111:0] random_beat();
        logic [15:0] f[7];
        int kind;
        int idx;
        kind = $urandom_range(99);
        for (int n = 0; n < 7; n++) begin
            f[n] = 16'($urandom);
        end
        if (kind >= 35 && kind < 65) begin
            // roughly unit-size quaternion
            for (int n = 0; n < 4; n++) begin
                f[n] = 16'($urandom_range(2 * 11585) - 11585);
            end
        end else if (kind >= 65 && kind < 80) begin
            for (int n = 0; n < 7; n++) begin
                f[n] = edge_value();
            end
        end else if (kind >= 80) begin
            for (int n = 0; n < 4; n++) begin
                f[n] = '0;
            end
            idx = $urandom_range(3);
            f[idx] = 16'($urandom);
        end
        return {f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    task automatic send_beat(input logic [111:0] beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(beat);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(pack_beat(0, 0, 0, 0, 0, 0, 0));
        send_beat(pack_beat(16384, 0, 0, 0, 32767, -32768, 1));
        send_beat(pack_beat(16384, 0, 0, 0, -1, 0, -32768));
        // exact halves: ties round up
        send_beat(pack_beat(8192, 0, 0, 0, 2, -2, 6));
        send_beat(pack_beat(8192, 0, 0, 0, -6, 1, -1));
        send_beat(pack_beat(0, 16384, 0, 0, 100, 200, 300));
        send_beat(pack_beat(0, 0, 16384, 0, -100, 200, -300));
        send_beat(pack_beat(0, 0, 0, 16384, 32767, 32767, 32767));
        send_beat(pack_beat(11585, 0, 0, 11585, 1000, 0, 0));
        send_beat(pack_beat(8192, 8192, 8192, 8192, 1, 2, 3));
        // norm^2 = 4: lands exactly on the output bound
        send_beat(pack_beat(-32768, 0, 0, 0, -32768, 32767, 0));
        send_beat(pack_beat(32767, 0, 0, 0, 32767, -32768, 32767));
        // one clipped component
        send_beat(pack_beat(-32768, -32768, 0, 0, 32767, 0, 0));
        send_beat(pack_beat(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_beat(pack_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_beat(pack_beat(32767, -32768, 32767, -32768, -32768, 32767, -32768));
        send_beat(pack_beat(-1, -1, -1, -1, -1, -1, -1));
        send_beat(pack_beat(1, 0, 0, 0, 32767, -32768, 32767));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_BEATS / 3; n++) begin
                send_beat(random_beat());
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(400000 * 2 * HALF_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule
